// ===== hw/rtl/pst_pkg.sv =====
package pst_pkg;

    // Default input sample width.
    localparam int SAMPLE_BITS_DEF = 12;

    // Divisor register.
    localparam int DIVISOR_W = 8;
    localparam logic [DIVISOR_W-1:0] DIVISOR_RESET = 8'd32;

    // Result widths that do not follow the sample width.
    localparam int ANGLE_W  = 17;
    localparam int DEGREE_W = 16;

    // CORDIC angle accumulator, in units of pi/2^19.
    localparam int CORDIC_STEPS = 16;
    localparam int Z_W = 22;
    localparam logic signed [Z_W-1:0] HALF_TURN = 22'sd524288;

    // Fractional scale applied to the differences before rotation.
    localparam int SCALE_SHIFT = 16;

    // Arctangent of 2^-i in units of pi/2^19, rounded to nearest.
    function automatic logic signed [Z_W-1:0] atan_unit(input int unsigned i);
        logic signed [Z_W-1:0] v;
        unique case (i)
            0:       v = 22'sd131072;
            1:       v = 22'sd77376;
            2:       v = 22'sd40884;
            3:       v = 22'sd20753;
            4:       v = 22'sd10417;
            5:       v = 22'sd5213;
            6:       v = 22'sd2607;
            7:       v = 22'sd1304;
            8:       v = 22'sd652;
            9:       v = 22'sd326;
            10:      v = 22'sd163;
            11:      v = 22'sd81;
            12:      v = 22'sd41;
            13:      v = 22'sd20;
            14:      v = 22'sd10;
            15:      v = 22'sd5;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/pst_front.sv =====
module pst_front
    import pst_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                                   clk,
    input  logic                                   en,
    input  logic [SAMPLE_BITS-1:0]                 i0,
    input  logic [SAMPLE_BITS-1:0]                 i45,
    input  logic [SAMPLE_BITS-1:0]                 i90,
    input  logic [SAMPLE_BITS-1:0]                 i135,
    input  logic [DIVISOR_W-1:0]                   divisor,
    output logic [SAMPLE_BITS+1:0]                 total_reg,
    output logic signed [SAMPLE_BITS:0]            h_reg,
    output logic signed [SAMPLE_BITS:0]            d_reg,
    output logic [DIVISOR_W+SAMPLE_BITS+1:0]       den_reg,
    output logic signed [SAMPLE_BITS+19:0]         x_reg,
    output logic signed [SAMPLE_BITS+19:0]         y_reg,
    output logic signed [Z_W-1:0]                  z_reg,
    output logic [2*SAMPLE_BITS:0]                 q_reg
);

    localparam int TOTAL_W = SAMPLE_BITS + 2;
    localparam int DIFF_W  = SAMPLE_BITS + 1;
    localparam int DEN_W   = DIVISOR_W + TOTAL_W;
    localparam int CW      = SAMPLE_BITS + 20;
    localparam int SQ_W    = 2 * SAMPLE_BITS;
    localparam int Q_W     = 2 * SAMPLE_BITS + 1;
    localparam int PAD_W   = CW - DIFF_W - SCALE_SHIFT;

    logic [TOTAL_W-1:0]        total_next;
    logic signed [DIFF_W-1:0]  h_next;
    logic signed [DIFF_W-1:0]  d_next;
    logic signed [2*DIFF_W-1:0] hh_full;
    logic signed [2*DIFF_W-1:0] dd_full;
    logic [SQ_W-1:0]           hh_reg;
    logic [SQ_W-1:0]           dd_reg;
    logic [DIVISOR_W-1:0]      div_eff;
    logic [DEN_W-1:0]          den_next;
    logic signed [CW-1:0]      xs;
    logic signed [CW-1:0]      ys;
    logic signed [CW-1:0]      x_next;
    logic signed [CW-1:0]      y_next;
    logic signed [Z_W-1:0]     z_next;
    logic [Q_W-1:0]            q_next;

    // First stage: sum and the two differences.
    always_comb
    begin
        total_next = {2'b00, i0} + {2'b00, i45} + {2'b00, i90} + {2'b00, i135};
        h_next = $signed({1'b0, i0}) - $signed({1'b0, i90});
        d_next = $signed({1'b0, i45}) - $signed({1'b0, i135});
    end

    // Second stage: squares, denominator and the CORDIC pre-rotation.
    always_comb
    begin
        hh_full = h_reg * h_reg;
        dd_full = d_reg * d_reg;
        div_eff = (divisor == '0) ? {{(DIVISOR_W-1){1'b0}}, 1'b1} : divisor;
        den_next = DEN_W'(div_eff) * DEN_W'(total_reg);
        xs = {{PAD_W{h_reg[DIFF_W-1]}}, h_reg, {SCALE_SHIFT{1'b0}}};
        ys = {{PAD_W{d_reg[DIFF_W-1]}}, d_reg, {SCALE_SHIFT{1'b0}}};
        // A vector in the left half plane is turned by a half circle first.
        if (h_reg < 0)
        begin
            z_next = (d_reg >= 0) ? HALF_TURN : -HALF_TURN;
            x_next = -xs;
            y_next = -ys;
        end
        else
        begin
            z_next = '0;
            x_next = xs;
            y_next = ys;
        end
    end

    // Third stage: sum of squares.
    assign q_next = {1'b0, hh_reg} + {1'b0, dd_reg};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            total_reg <= total_next;
            h_reg     <= h_next;
            d_reg     <= d_next;
            hh_reg    <= hh_full[SQ_W-1:0];
            dd_reg    <= dd_full[SQ_W-1:0];
            den_reg   <= den_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            z_reg     <= z_next;
            q_reg     <= q_next;
        end
    end

endmodule

// ===== hw/rtl/pst_cordic_step.sv =====
module pst_cordic_step
    import pst_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int STEP = 0
)
(
    input  logic                           clk,
    input  logic                           en,
    input  logic signed [SAMPLE_BITS+19:0] x,
    input  logic signed [SAMPLE_BITS+19:0] y,
    input  logic signed [Z_W-1:0]          z,
    output logic signed [SAMPLE_BITS+19:0] x_reg,
    output logic signed [SAMPLE_BITS+19:0] y_reg,
    output logic signed [Z_W-1:0]          z_reg
);

    localparam int CW = SAMPLE_BITS + 20;

    logic signed [CW-1:0]  xs;
    logic signed [CW-1:0]  ys;
    logic signed [CW-1:0]  x_next;
    logic signed [CW-1:0]  y_next;
    logic signed [Z_W-1:0] z_next;

    // One vectoring rotation toward the positive x axis.
    always_comb
    begin
        xs = x >>> STEP;
        ys = y >>> STEP;
        if (y > 0)
        begin
            x_next = x + ys;
            y_next = y - xs;
            z_next = z + atan_unit(STEP);
        end
        else
        begin
            x_next = x - ys;
            y_next = y + xs;
            z_next = z - atan_unit(STEP);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

endmodule

// ===== hw/rtl/pst_sqrt_step.sv =====
module pst_sqrt_step
    import pst_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          en,
    input  logic [2*SAMPLE_BITS+31:0]     rad,
    input  logic [SAMPLE_BITS+17:0]       rem,
    input  logic [SAMPLE_BITS+15:0]       root,
    output logic [2*SAMPLE_BITS+31:0]     rad_reg,
    output logic [SAMPLE_BITS+17:0]       rem_reg,
    output logic [SAMPLE_BITS+15:0]       root_reg
);

    localparam int RW     = 2 * SAMPLE_BITS + 32;
    localparam int ROOT_W = SAMPLE_BITS + 16;
    localparam int REM_W  = ROOT_W + 2;

    logic [REM_W-1:0]  cur;
    logic [REM_W-1:0]  trial;
    logic              fits;
    logic [REM_W-1:0]  rem_next;
    logic [ROOT_W-1:0] root_next;

    // One result bit: bring down two radicand bits and try 4*root+1.
    always_comb
    begin
        cur   = {rem[REM_W-3:0], rad[RW-1:RW-2]};
        trial = {root, 2'b01};
        fits  = (cur >= trial);
        rem_next  = fits ? (cur - trial) : cur;
        root_next = {root[ROOT_W-2:0], fits};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg  <= {rad[RW-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

endmodule

// ===== hw/rtl/pst_div_step.sv =====
module pst_div_step
    import pst_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int K = 0
)
(
    input  logic                               clk,
    input  logic                               en,
    input  logic [SAMPLE_BITS+17:0]            rem,
    input  logic [DEGREE_W-1:0]                quo,
    input  logic [DIVISOR_W+SAMPLE_BITS+1:0]   den,
    input  logic                               sat,
    output logic [SAMPLE_BITS+17:0]            rem_reg,
    output logic [DEGREE_W-1:0]                quo_reg,
    output logic [DIVISOR_W+SAMPLE_BITS+1:0]   den_reg,
    output logic                               sat_reg
);

    localparam int NW    = SAMPLE_BITS + 18;
    localparam int DEN_W = DIVISOR_W + SAMPLE_BITS + 2;
    localparam int CMP_W = DEN_W + DEGREE_W;

    logic [CMP_W-1:0]    shifted;
    logic [CMP_W-1:0]    rem_ext;
    logic [CMP_W-1:0]    diff;
    logic                fits;
    logic [DEGREE_W-1:0] quo_next;

    // Restoring division: one quotient bit of weight 2^K.
    always_comb
    begin
        shifted  = CMP_W'(den) << K;
        rem_ext  = CMP_W'(rem);
        fits     = (rem_ext >= shifted);
        diff     = rem_ext - shifted;
        quo_next = quo;
        quo_next[K] = fits;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= fits ? diff[NW-1:0] : rem;
            quo_reg <= quo_next;
            den_reg <= den;
            sat_reg <= sat;
        end
    end

endmodule

// ===== hw/rtl/polarization_stokes_pixel.sv =====
// Per-pixel Stokes unit for a four-angle polarization sensor. One pixel of
// four intensities is taken per clock and one result leaves per clock; the
// latency is set by the square root, which resolves one result bit per
// stage, followed by a sixteen-stage quotient for the degree of
// polarization. The angle runs in a sixteen-stage CORDIC alongside. When
// the output is stalled the whole pipeline holds and in_stall is raised.
// The divisor register is written through the cfg channel, which is always
// ready; a written zero acts as one.
module polarization_stokes_pixel
    import pst_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [SAMPLE_BITS-1:0]      intensity_0,
    input  logic [SAMPLE_BITS-1:0]      intensity_45,
    input  logic [SAMPLE_BITS-1:0]      intensity_90,
    input  logic [SAMPLE_BITS-1:0]      intensity_135,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [DIVISOR_W-1:0]        cfg_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [SAMPLE_BITS+1:0]      total_doubled,
    output logic signed [SAMPLE_BITS:0] linear_h,
    output logic signed [SAMPLE_BITS:0] linear_d,
    output logic signed [ANGLE_W-1:0]   angle,
    output logic [DEGREE_W-1:0]         degree,
    output logic                        zero_total
);

    localparam int TOTAL_W = SAMPLE_BITS + 2;
    localparam int DIFF_W  = SAMPLE_BITS + 1;
    localparam int DEN_W   = DIVISOR_W + TOTAL_W;
    localparam int CW      = SAMPLE_BITS + 20;
    localparam int Q_W     = 2 * SAMPLE_BITS + 1;
    localparam int RW      = 2 * SAMPLE_BITS + 32;
    localparam int ROOT_W  = SAMPLE_BITS + 16;
    localparam int REM_W   = ROOT_W + 2;
    localparam int NW      = ROOT_W + 2;
    localparam int CMP_W   = DEN_W + DEGREE_W;
    // Stage numbers: front ends at 3, square root ends at SQ_END.
    localparam int SQ_END  = 3 + ROOT_W;
    localparam int DEPTH   = SQ_END + DEGREE_W + 2;
    localparam int CORD_END = CORDIC_STEPS + 2;
    localparam int ANG_ST   = CORD_END + 1;
    localparam logic signed [Z_W-1:0] ANG_MIN = -22'sd32768;
    localparam logic signed [Z_W-1:0] ANG_FLIP = 22'sd32768;

    typedef struct packed {
        logic [TOTAL_W-1:0]       total;
        logic signed [DIFF_W-1:0] h;
        logic signed [DIFF_W-1:0] d;
    } side_t;

    logic                      en;
    logic [DIVISOR_W-1:0]      divisor_reg;
    logic                      vld_reg [1:DEPTH-1];

    logic [TOTAL_W-1:0]        f_total;
    logic signed [DIFF_W-1:0]  f_h;
    logic signed [DIFF_W-1:0]  f_d;
    logic [DEN_W-1:0]          f_den;
    logic [Q_W-1:0]            f_q;

    side_t                     side_w   [1:DEPTH-1];
    side_t                     side_reg [2:DEPTH-1];
    logic [DEN_W-1:0]          den_w    [2:SQ_END];
    logic [DEN_W-1:0]          den_reg  [3:SQ_END];

    logic signed [CW-1:0]      cx [0:CORDIC_STEPS];
    logic signed [CW-1:0]      cy [0:CORDIC_STEPS];
    logic signed [Z_W-1:0]     cz [0:CORDIC_STEPS];

    logic [RW-1:0]             sq_rad  [0:ROOT_W];
    logic [REM_W-1:0]          sq_rem  [0:ROOT_W];
    logic [ROOT_W-1:0]         sq_root [0:ROOT_W];

    logic [NW-1:0]             dv_rem [0:DEGREE_W];
    logic [DEGREE_W-1:0]       dv_quo [0:DEGREE_W];
    logic [DEN_W-1:0]          dv_den [0:DEGREE_W];
    logic                      dv_sat [0:DEGREE_W];

    logic [NW-1:0]             num;
    logic                      sat_next;
    logic signed [Z_W-1:0]     z_clamp;
    logic signed [Z_W-1:0]     z_round;
    logic signed [Z_W-1:0]     ang_full;
    logic signed [ANGLE_W-1:0] ang_next;
    logic signed [ANGLE_W-1:0] ang_reg [ANG_ST:DEPTH-1];
    logic                      zero_next;
    logic [DEGREE_W-1:0]       degree_next;

    // The pipeline advances unless a finished result is being held.
    assign en        = !(out_valid && out_stall);
    assign in_stall  = !en;
    assign cfg_ready = 1'b1;

    // Divisor register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            divisor_reg <= DIVISOR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            divisor_reg <= cfg_data;
        end
    end

    // Valid bits that travel with each pixel.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 1; s < DEPTH; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
            out_valid <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[1] <= in_valid;
            for (int s = 2; s < DEPTH; s++)
            begin
                vld_reg[s] <= vld_reg[s-1];
            end
            out_valid <= vld_reg[DEPTH-1];
        end
    end

    pst_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
        .clk       (clk),
        .en        (en),
        .i0        (intensity_0),
        .i45       (intensity_45),
        .i90       (intensity_90),
        .i135      (intensity_135),
        .divisor   (divisor_reg),
        .total_reg (f_total),
        .h_reg     (f_h),
        .d_reg     (f_d),
        .den_reg   (f_den),
        .x_reg     (cx[0]),
        .y_reg     (cy[0]),
        .z_reg     (cz[0]),
        .q_reg     (f_q)
    );

    // Delay lines for the pass-through fields and the denominator.
    always_comb
    begin
        side_w[1] = '{total: f_total, h: f_h, d: f_d};
        for (int s = 2; s < DEPTH; s++)
        begin
            side_w[s] = side_reg[s];
        end
        den_w[2] = f_den;
        for (int s = 3; s <= SQ_END; s++)
        begin
            den_w[s] = den_reg[s];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 2; s < DEPTH; s++)
            begin
                side_reg[s] <= side_w[s-1];
            end
            for (int s = 3; s <= SQ_END; s++)
            begin
                den_reg[s] <= den_w[s-1];
            end
        end
    end

    // CORDIC vectoring chain for the angle.
    genvar gi;
    generate
        for (gi = 0; gi < CORDIC_STEPS; gi++)
        begin : g_cordic
            pst_cordic_step #(.SAMPLE_BITS(SAMPLE_BITS), .STEP(gi)) u_step (
                .clk   (clk),
                .en    (en),
                .x     (cx[gi]),
                .y     (cy[gi]),
                .z     (cz[gi]),
                .x_reg (cx[gi+1]),
                .y_reg (cy[gi+1]),
                .z_reg (cz[gi+1])
            );
        end
    endgenerate

    // Clamp, round to the output unit and handle the on-axis cases.
    always_comb
    begin
        if (cz[CORDIC_STEPS] > HALF_TURN)
        begin
            z_clamp = HALF_TURN;
        end
        else if (cz[CORDIC_STEPS] < -HALF_TURN)
        begin
            z_clamp = -HALF_TURN;
        end
        else
        begin
            z_clamp = cz[CORDIC_STEPS];
        end
        z_round  = (z_clamp + 22'sd8) >>> 4;
        ang_full = (z_round <= ANG_MIN) ? ANG_FLIP : z_round;
        if (side_w[CORD_END].d == 0)
        begin
            ang_next = (side_w[CORD_END].h < 0) ? ANGLE_W'(ANG_FLIP) : '0;
        end
        else
        begin
            ang_next = ang_full[ANGLE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ang_reg[ANG_ST] <= ang_next;
            for (int s = ANG_ST + 1; s < DEPTH; s++)
            begin
                ang_reg[s] <= ang_reg[s-1];
            end
        end
    end

    // Square root of the sum of squares scaled by 2^30.
    assign sq_rad[0]  = {1'b0, f_q, 30'b0};
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;

    generate
        for (gi = 0; gi < ROOT_W; gi++)
        begin : g_sqrt
            pst_sqrt_step #(.SAMPLE_BITS(SAMPLE_BITS)) u_step (
                .clk      (clk),
                .en       (en),
                .rad      (sq_rad[gi]),
                .rem      (sq_rem[gi]),
                .root     (sq_root[gi]),
                .rad_reg  (sq_rad[gi+1]),
                .rem_reg  (sq_rem[gi+1]),
                .root_reg (sq_root[gi+1])
            );
        end
    endgenerate

    // Numerator and saturation test ahead of the quotient.
    always_comb
    begin
        num      = {sq_root[ROOT_W], 2'b00};
        sat_next = (CMP_W'(num) >= (CMP_W'(den_w[SQ_END]) << DEGREE_W));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_rem[0] <= num;
            dv_quo[0] <= '0;
            dv_den[0] <= den_w[SQ_END];
            dv_sat[0] <= sat_next;
        end
    end

    generate
        for (gi = 0; gi < DEGREE_W; gi++)
        begin : g_div
            pst_div_step #(.SAMPLE_BITS(SAMPLE_BITS), .K(DEGREE_W - 1 - gi)) u_step (
                .clk     (clk),
                .en      (en),
                .rem     (dv_rem[gi]),
                .quo     (dv_quo[gi]),
                .den     (dv_den[gi]),
                .sat     (dv_sat[gi]),
                .rem_reg (dv_rem[gi+1]),
                .quo_reg (dv_quo[gi+1]),
                .den_reg (dv_den[gi+1]),
                .sat_reg (dv_sat[gi+1])
            );
        end
    endgenerate

    // Output register.
    always_comb
    begin
        zero_next = (side_w[DEPTH-1].total == '0);
        priority if (zero_next)
        begin
            degree_next = '0;
        end
        else if (dv_sat[DEGREE_W])
        begin
            degree_next = '1;
        end
        else
        begin
            degree_next = dv_quo[DEGREE_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            total_doubled <= side_w[DEPTH-1].total;
            linear_h      <= side_w[DEPTH-1].h;
            linear_d      <= side_w[DEPTH-1].d;
            angle         <= ang_reg[DEPTH-1];
            degree        <= degree_next;
            zero_total    <= zero_next;
        end
    end

endmodule

// ===== test/polarization_stokes_pixel_check.sv =====
`timescale 1ns / 1ps

// Watches the pixel, divisor and result channels, predicts each result and
// compares it field by field with what the block returns.
module polarization_stokes_pixel_check
    import pst_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [11:0]        intensity_0,
    input  logic [11:0]        intensity_45,
    input  logic [11:0]        intensity_90,
    input  logic [11:0]        intensity_135,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [DIVISOR_W-1:0] cfg_data,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [13:0]        total_doubled,
    input  logic signed [12:0] linear_h,
    input  logic signed [12:0] linear_d,
    input  logic signed [ANGLE_W-1:0] angle,
    input  logic [DEGREE_W-1:0] degree,
    input  logic               zero_total,
    output int                 mismatches,
    output int                 pending
);

    typedef struct packed {
        logic [13:0]               total;
        logic signed [12:0]        h;
        logic signed [12:0]        d;
        logic signed [ANGLE_W-1:0] ang;
        logic [DEGREE_W-1:0]       deg;
        logic                      zero;
    } stokes_t;

    // Arctangent of 2^-i in units of pi/2^19.
    localparam longint ATAN_STEP [16] = '{
        131072, 77376, 40884, 20753, 10417, 5213, 2607, 1304,
        652, 326, 163, 81, 41, 20, 10, 5
    };

    stokes_t expected_pixels[$];
    logic [DIVISOR_W-1:0] divisor;

    assign pending = expected_pixels.size();

    // Bitwise integer square root.
    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Half of atan2(d, h) by vectoring CORDIC, in units of pi/65536.
    function automatic longint half_angle(input longint h, input longint d);
        longint x, y, z, xs, ys, a;
        if (d == 0)
            return (h < 0) ? 32768 : 0;
        x = h * 65536;
        y = d * 65536;
        z = 0;
        if (x < 0)
        begin
            z = (y >= 0) ? 524288 : -524288;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < 16; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_STEP[i];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_STEP[i];
            end
        end
        if (z > 524288)
            z = 524288;
        if (z < -524288)
            z = -524288;
        a = (z + 8) >>> 4;
        if (a <= -32768)
            a = 32768;
        return a;
    endfunction

    function automatic stokes_t predict_stokes(input longint i0, input longint i45,
                                               input longint i90, input longint i135,
                                               input logic [DIVISOR_W-1:0] div);
        stokes_t r;
        longint total, h, d, den;
        longint unsigned s, q;
        total = i0 + i45 + i90 + i135;
        h = i0 - i90;
        d = i45 - i135;
        r.total = total[13:0];
        r.h = h[12:0];
        r.d = d[12:0];
        r.ang = ANGLE_W'(half_angle(h, d));
        r.deg = '0;
        r.zero = (total == 0);
        if (total != 0)
        begin
            q = h * h + d * d;
            s = int_sqrt(q << 30);
            den = ((div == 0) ? 1 : div) * total;
            q = (4 * s) / den;
            r.deg = (q > 65535) ? 16'hFFFF : q[15:0];
        end
        return r;
    endfunction

    task automatic report(input string field, input longint got, input longint want);
        $display("%0t: %s mismatch, got %0d, expected %0d", $realtime, field, got, want);
        mismatches++;
    endtask

    initial
        mismatches = 0;

    // Track the register, queue predictions and compare each result transfer.
    always @(posedge clk or negedge rst_n)
    begin
        stokes_t w;
        if (!rst_n)
        begin
            divisor <= DIVISOR_RESET;
            expected_pixels.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                divisor <= cfg_data;
            if (out_valid && !out_stall)
            begin
                if (expected_pixels.size() == 0)
                    report("unexpected result", total_doubled, 0);
                else
                begin
                    w = expected_pixels.pop_front();
                    if (total_doubled !== w.total)
                        report("total_doubled", total_doubled, w.total);
                    if (linear_h !== w.h)
                        report("linear_h", linear_h, w.h);
                    if (linear_d !== w.d)
                        report("linear_d", linear_d, w.d);
                    if (angle !== w.ang)
                        report("angle", angle, w.ang);
                    if (degree !== w.deg)
                        report("degree", degree, w.deg);
                    if (zero_total !== w.zero)
                        report("zero_total", zero_total, w.zero);
                end
            end
            if (in_valid && !in_stall)
                expected_pixels = {expected_pixels,
                                   predict_stokes(intensity_0, intensity_45,
                                                  intensity_90, intensity_135,
                                                  divisor)};
        end
    end

endmodule

// ===== test/polarization_stokes_pixel_test.sv =====
`timescale 1ns / 1ps

module polarization_stokes_pixel_test;
    import pst_pkg::*;

    localparam int LATENCY_WAIT = 60;
    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_AFTER = 560;
    localparam int HOLD_CYCLES = 400;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [11:0] intensity_0 = '0;
    logic [11:0] intensity_45 = '0;
    logic [11:0] intensity_90 = '0;
    logic [11:0] intensity_135 = '0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [DIVISOR_W-1:0] cfg_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [13:0] total_doubled;
    logic signed [12:0] linear_h;
    logic signed [12:0] linear_d;
    logic signed [ANGLE_W-1:0] angle;
    logic [DEGREE_W-1:0] degree;
    logic zero_total;
    int mismatches;
    int pending;
    int cycle_count = 0;
    int quiet_cycles = 0;
    int accepted = 0;
    int hold_left = 0;
    bit hold_done = 0;
    bit sender_steady = 0;

    polarization_stokes_pixel dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .intensity_0(intensity_0), .intensity_45(intensity_45),
        .intensity_90(intensity_90), .intensity_135(intensity_135),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .out_valid(out_valid), .out_stall(out_stall),
        .total_doubled(total_doubled), .linear_h(linear_h), .linear_d(linear_d),
        .angle(angle), .degree(degree), .zero_total(zero_total)
    );

    polarization_stokes_pixel_check check (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .intensity_0(intensity_0), .intensity_45(intensity_45),
        .intensity_90(intensity_90), .intensity_135(intensity_135),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .out_valid(out_valid), .out_stall(out_stall),
        .total_doubled(total_doubled), .linear_h(linear_h), .linear_d(linear_d),
        .angle(angle), .degree(degree), .zero_total(zero_total),
        .mismatches(mismatches), .pending(pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side: random stalls, one long hold-off in the middle of a
    // phase while pixels keep coming, and one stretch with no stalls.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (in_valid && !in_stall)
            accepted <= accepted + 1;
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && accepted >= HOLD_AFTER)
        begin
            out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (cycle_count >= 2200 && cycle_count < 2800)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < 13);
    end

    // Watchdog on cycles with no transfer on either data channel.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("** polarization_stokes_pixel: FAILED **");
            $finish;
        end
    end

    // Offer one pixel, sometimes after idle cycles, and wait for its transfer.
    task automatic send_pixel(input logic [11:0] a, input logic [11:0] b,
                              input logic [11:0] c, input logic [11:0] d);
        while (!sender_steady && $urandom_range(99) < 13)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        intensity_0 <= a;
        intensity_45 <= b;
        intensity_90 <= c;
        intensity_135 <= d;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Drain the pipeline, then write the divisor.
    task automatic write_divisor(input logic [DIVISOR_W-1:0] value);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY_WAIT) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // A random pixel drawn from one of several shapes.
    task automatic send_random;
        logic [11:0] a, b, c, d;
        a = 12'($urandom);
        b = 12'($urandom);
        c = 12'($urandom);
        d = 12'($urandom);
        case ($urandom_range(5))
            0:
            begin
                a = 12'($urandom_range(3));
                b = 12'($urandom_range(3));
                c = 12'($urandom_range(3));
                d = 12'($urandom_range(3));
            end
            1: c = a;
            2: d = b;
            3:
            begin
                b = 12'($urandom_range(2));
                c = 12'($urandom_range(2));
                d = 12'($urandom_range(2));
            end
            default: ;
        endcase
        send_pixel(a, b, c, d);
    endtask

    initial
    begin
        logic [DIVISOR_W-1:0] phase_div[8];
        phase_div = '{8'd1, 8'd255, 8'd0, 8'd2, 8'd7, 8'd32, 8'd100, 8'd1};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed pixels at the reset divisor.
        send_pixel(12'd0, 12'd0, 12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095, 12'd4095, 12'd4095);
        send_pixel(12'd4095, 12'd0, 12'd0, 12'd0);
        send_pixel(12'd0, 12'd4095, 12'd0, 12'd0);
        send_pixel(12'd0, 12'd0, 12'd4095, 12'd0);
        send_pixel(12'd0, 12'd0, 12'd0, 12'd4095);
        send_pixel(12'd4095, 12'd0, 12'd4095, 12'd0);
        send_pixel(12'd0, 12'd5, 12'd100, 12'd5);
        send_pixel(12'd100, 12'd5, 12'd0, 12'd5);
        send_pixel(12'd0, 12'd0, 12'd4095, 12'd1);
        send_pixel(12'd0, 12'd1, 12'd4095, 12'd0);
        send_pixel(12'd0, 12'd0, 12'd1, 12'd1);
        send_pixel(12'd1, 12'd0, 12'd0, 12'd0);
        send_pixel(12'd2730, 12'd1365, 12'd2730, 12'd1365);

        // Saturating degree, zero divisor and the largest divisor.
        write_divisor(8'd1);
        send_pixel(12'd4095, 12'd0, 12'd0, 12'd0);
        send_pixel(12'd1, 12'd0, 12'd0, 12'd0);
        send_pixel(12'd0, 12'd0, 12'd0, 12'd0);
        write_divisor(8'd0);
        send_pixel(12'd4095, 12'd4095, 12'd0, 12'd0);
        send_pixel(12'd3, 12'd0, 12'd1, 12'd0);
        write_divisor(8'd255);
        send_pixel(12'd4095, 12'd0, 12'd0, 12'd4095);
        send_pixel(12'd1, 12'd1, 12'd1, 12'd1);

        // Random phases across divisor settings; one phase with no gaps.
        for (int p = 0; p < 8; p++)
        begin
            write_divisor((p == 5) ? 8'($urandom_range(1, 255)) : phase_div[p]);
            sender_steady = (p == 3);
            repeat (215) send_random();
        end
        sender_steady = 0;

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY_WAIT) @(posedge clk);
        if (mismatches == 0)
            $display("** polarization_stokes_pixel: PASSED **");
        else
            $display("** polarization_stokes_pixel: FAILED **");
        $finish;
    end

endmodule
